### src/fcd_pkg.sv
// Shared types, constants and arithmetic helpers for the flanger / chorus delay block.
package fcd_pkg;

  // Widths of the audio samples, store words and configuration port.
  localparam int SAMPLE_W = 16;
  localparam int WORD_W   = 18;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 17;
  localparam int GAIN_W   = 16;
  localparam int RATE_W   = 17;
  localparam int DLY_W    = 12;
  localparam int POS_W    = 32;
  localparam int IPART_W  = 16;
  localparam int BND_W    = 17;

  // Shared multiplier operand and product widths.
  localparam int A_W = 36;
  localparam int B_W = 18;
  localparam int P_W = A_W + B_W;
  localparam int S_W = P_W;
  localparam int Q_W = S_W - 31;

  // Tap sum before reduction into the store range.
  localparam int SUM_W = IPART_W + 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_AW-1:0] REG_DRY   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_WET   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_FB    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_RATE  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_DEPTH = 3'd4;
  localparam logic [CFG_AW-1:0] REG_BASE  = 3'd5;

  // Register reset values.
  localparam logic [GAIN_W-1:0] DRY_RST   = 16'd32735;
  localparam logic [GAIN_W-1:0] WET_RST   = 16'd32735;
  localparam logic [GAIN_W-1:0] FB_RST    = 16'd0;
  localparam logic [RATE_W-1:0] RATE_RST  = 17'd131;
  localparam logic [DLY_W-1:0]  DEPTH_RST = 12'd96;
  localparam logic [DLY_W-1:0]  BASE_RST  = 12'd0;

  // Step value whose negation does not fit; it turns into the largest positive step.
  localparam logic [RATE_W-1:0] STEP_MOST_NEG = 17'h10000;
  localparam logic [RATE_W-1:0] STEP_MOST_POS = 17'h0FFFF;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEAR,
    ST_FAR,
    ST_DSUM,
    ST_FB,
    ST_WET,
    ST_DRY,
    ST_SUMY,
    ST_OUT,
    ST_TAP
  } fcd_state_t;

  // Operand selection for the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_NEAR,
    MUL_FAR,
    MUL_FB,
    MUL_WET,
    MUL_DRY
  } fcd_mul_sel_t;

  // Divide by 2^31, truncating toward zero.
  function automatic logic signed [Q_W-1:0] div31(input logic signed [S_W-1:0] s);
    logic signed [Q_W-1:0] q;
    q = Q_W'(s >>> 31);
    if (s[S_W-1] && (s[30:0] != '0)) begin
      q = q + Q_W'(1);
    end
    return q;
  endfunction

  // Saturate a quotient to the 18-bit store word.
  function automatic logic signed [WORD_W-1:0] sat18(input logic signed [Q_W-1:0] q);
    logic signed [WORD_W-1:0] r;
    if (q > $signed(Q_W'(131071))) begin
      r = 18'sh1FFFF;
    end else if (q < -$signed(Q_W'(131072))) begin
      r = -18'sh20000;
    end else begin
      r = WORD_W'(q);
    end
    return r;
  endfunction

  // Saturate a quotient to a 16-bit audio sample.
  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [Q_W-1:0] q);
    logic signed [SAMPLE_W-1:0] r;
    if (q > $signed(Q_W'(32767))) begin
      r = 16'sh7FFF;
    end else if (q < -$signed(Q_W'(32768))) begin
      r = -16'sh8000;
    end else begin
      r = SAMPLE_W'(q);
    end
    return r;
  endfunction

endpackage

### src/flanger_chorus_delay.sv
// Modulated delay line for flanging and chorus: sequencer, registers and datapath.
//
// Usage:
//   Input samples arrive on the in_ stream channel and mixed samples leave on
//   the out_ stream channel, one result for every accepted request. The six
//   control registers are written through cfg_we / cfg_addr / cfg_wdata while
//   the block is idle; a write to the sweep rate, depth or base delay
//   recenters the sweep on the following cycle.
//   Each sample is processed by one shared multiplier under a sequencer: two
//   store reads, five multiplies and the store write, after which the result
//   is registered on out_tdata and out_tvalid rises. The next tap address is
//   then reduced modulo the store depth by a reciprocal multiply and one
//   compare-subtract, and only after that is the next sample accepted, so a
//   new sample is never taken before the last one has gone through the whole
//   sequence. in_tready is high only while the sequencer is idle.
//   The store is not swept at reset: a written-region tracker (write index and
//   wrap flag) makes never-written entries read as zero, so the block accepts
//   samples right after reset. If the receiver stalls, the finished result
//   waits in the output register and the sequencer holds before loading the
//   next one.
module flanger_chorus_delay import fcd_pkg::*; #(
  parameter int STORE_DEPTH = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  // sample_in [15:0]
  input  logic [15:0]       in_tdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  // sample_out [15:0]
  output logic [15:0]       out_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [BND_W-1:0] MAX_BASE = BND_W'(STORE_DEPTH - 2);
  localparam logic [AW-1:0]    LAST_IDX = AW'(STORE_DEPTH - 1);

  // Configuration registers.
  logic [GAIN_W-1:0] dry_r, wet_r, fb_r;
  logic [RATE_W-1:0] rate_r;
  logic [DLY_W-1:0]  depth_r, base_r;
  logic              restart_r;

  // Sweep and addressing state.
  logic [AW-1:0]     widx_r, tap_near_r, tap_far_r;
  logic              wrapped_r;
  logic [POS_W-1:0]  pos_r;
  logic [RATE_W-1:0] step_r;

  // Sequencer.
  fcd_state_t   state_r, state_nxt;
  fcd_mul_sel_t mul_sel;
  logic         store_we, out_load, rd_far, out_free;

  // Datapath registers.
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [A_W-1:0]      d_r;
  logic signed [S_W-1:0]      s_r;
  logic [SAMPLE_W-1:0]        out_tdata_r;
  logic                       out_tvalid_r;
  logic                       rd_ok_r;

  // Shared unit connections.
  logic signed [A_W-1:0]  mul_a;
  logic signed [B_W-1:0]  mul_b;
  logic signed [P_W-1:0]  p_r;
  logic [AW-1:0]          raddr;
  logic [WORD_W-1:0]      rdata_r;
  logic signed [WORD_W-1:0] tap_word;
  logic [SUM_W-1:0]       mod_sum;
  logic                   mod_done;
  logic [AW-1:0]          mod_rem;

  // Sweep bounds and next position.
  logic [BND_W-1:0]   base_c, mx, depth_c, lo, mid_sum;
  logic [POS_W-1:0]   pos_nxt;
  logic [IPART_W-1:0] ipart_nxt;
  logic [AW-1:0]      widx_inc;
  logic               reverse;
  logic signed [S_W-1:0] x_ext;

  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

  // Bounds of the sweep with base delay and depth clamped into the store.
  always_comb begin
    base_c  = (BND_W'(base_r) > MAX_BASE) ? MAX_BASE : BND_W'(base_r);
    mx      = MAX_BASE - base_c;
    depth_c = (BND_W'(depth_r) > mx) ? mx : BND_W'(depth_r);
    lo      = mx - depth_c;
    mid_sum = lo + mx;
  end

  // Position, write index and step direction after this sample.
  always_comb begin
    pos_nxt   = pos_r + POS_W'(signed'(step_r));
    ipart_nxt = pos_nxt[POS_W-1:POS_W-IPART_W];
    widx_inc  = (widx_r == LAST_IDX) ? '0 : widx_r + AW'(1);
    mod_sum   = SUM_W'(widx_inc) + SUM_W'(ipart_nxt);
    reverse   = (BND_W'(ipart_nxt) > mx) || (BND_W'(ipart_nxt) < lo);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_NEAR;
      ST_NEAR: state_nxt = ST_FAR;
      ST_FAR:  state_nxt = ST_DSUM;
      ST_DSUM: state_nxt = ST_FB;
      ST_FB:   state_nxt = ST_WET;
      ST_WET:  state_nxt = ST_DRY;
      ST_DRY:  state_nxt = ST_SUMY;
      ST_SUMY: state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_TAP;
      ST_TAP:  if (mod_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = 1'b0;
    mul_sel   = MUL_NONE;
    store_we  = 1'b0;
    out_load  = 1'b0;
    rd_far    = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_NEAR: begin
        mul_sel = MUL_NEAR;
        rd_far  = 1'b1;
      end
      ST_FAR:  mul_sel = MUL_FAR;
      ST_FB:   mul_sel = MUL_FB;
      ST_WET:  mul_sel = MUL_WET;
      ST_DRY: begin
        mul_sel  = MUL_DRY;
        store_we = 1'b1;
      end
      ST_OUT:  out_load = out_free;
      default: ;
    endcase
  end

  // Store read address and never-written entries reading as zero.
  assign raddr    = rd_far ? tap_far_r : tap_near_r;
  assign tap_word = rd_ok_r ? signed'(rdata_r) : '0;

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mul_sel)
      MUL_NEAR: begin
        mul_a = A_W'(tap_word);
        mul_b = signed'({2'b00, pos_r[15:0]});
      end
      MUL_FAR: begin
        mul_a = A_W'(tap_word);
        mul_b = signed'(B_W'(18'h10000 - {2'b00, pos_r[15:0]}));
      end
      MUL_FB: begin
        mul_a = d_r;
        mul_b = B_W'(signed'(fb_r));
      end
      MUL_WET: begin
        mul_a = d_r;
        mul_b = B_W'(signed'(wet_r));
      end
      MUL_DRY: begin
        mul_a = A_W'(x_r);
        mul_b = B_W'(signed'(dry_r));
      end
      default: ;
    endcase
  end

  assign x_ext = S_W'(x_r);

  fcd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  fcd_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (store_we),
    .waddr   (widx_r),
    .wdata   (sat18(div31(s_r))),
    .raddr   (raddr),
    .rdata_r (rdata_r)
  );

  fcd_tap_mod #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_tap_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (out_load),
    .sum   (mod_sum),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // Configuration registers and the recenter request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dry_r     <= DRY_RST;
      wet_r     <= WET_RST;
      fb_r      <= FB_RST;
      rate_r    <= RATE_RST;
      depth_r   <= DEPTH_RST;
      base_r    <= BASE_RST;
      restart_r <= 1'b1;
    end else begin
      restart_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_addr)
          REG_DRY:   dry_r <= cfg_wdata[GAIN_W-1:0];
          REG_WET:   wet_r <= cfg_wdata[GAIN_W-1:0];
          REG_FB:    fb_r  <= cfg_wdata[GAIN_W-1:0];
          REG_RATE: begin
            rate_r    <= cfg_wdata[RATE_W-1:0];
            restart_r <= 1'b1;
          end
          REG_DEPTH: begin
            depth_r   <= cfg_wdata[DLY_W-1:0];
            restart_r <= 1'b1;
          end
          REG_BASE: begin
            base_r    <= cfg_wdata[DLY_W-1:0];
            restart_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Sequencer, sweep, addressing and output handshake state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      widx_r       <= '0;
      wrapped_r    <= 1'b0;
      tap_near_r   <= '0;
      tap_far_r    <= '0;
      pos_r        <= '0;
      step_r       <= RATE_RST;
      out_tvalid_r <= 1'b0;
      rd_ok_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_ok_r <= wrapped_r || (raddr < widx_r);
      if (restart_r) begin
        pos_r  <= {mid_sum[IPART_W:1], 16'h0000};
        step_r <= rate_r;
      end else if (out_load) begin
        pos_r <= pos_nxt;
        if (reverse) begin
          step_r <= (step_r == STEP_MOST_NEG) ? STEP_MOST_POS : RATE_W'(-step_r);
        end
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
        widx_r       <= widx_inc;
        if (widx_r == LAST_IDX) begin
          wrapped_r <= 1'b1;
        end
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if ((state_r == ST_TAP) && mod_done) begin
        tap_near_r <= mod_rem;
        tap_far_r  <= (mod_rem == '0) ? LAST_IDX : mod_rem - AW'(1);
      end
    end
  end

  // Datapath: sample capture, delayed value, accumulations and result.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      x_r <= signed'(in_tdata);
    end
    case (state_r)
      ST_FAR:  d_r <= A_W'(p_r);
      ST_DSUM: d_r <= d_r + A_W'(p_r);
      ST_WET:  s_r <= (x_ext <<< 31) + p_r;
      ST_DRY:  s_r <= p_r;
      ST_SUMY: s_r <= s_r + (p_r <<< 16);
      default: ;
    endcase
    if (out_load) begin
      out_tdata_r <= sat16(div31(s_r));
    end
  end

endmodule

### src/fcd_store.sv
// Circular delay store: one write port and one registered read port.
module fcd_store import fcd_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata_r
);

  logic [WORD_W-1:0] mem [DEPTH];

  // Write side.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read side, data registered.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

### src/fcd_mul.sv
// Shared signed multiplier with a registered product.
module fcd_mul import fcd_pkg::*; (
  input  logic                  clk,
  input  logic signed [A_W-1:0] a,
  input  logic signed [B_W-1:0] b,
  output logic signed [P_W-1:0] p_r
);

  // One product per cycle, registered before any further use.
  always_ff @(posedge clk) begin
    p_r <= P_W'(a) * P_W'(b);
  end

endmodule

### src/fcd_tap_mod.sv
// Reduction of the tap sum modulo the store depth by reciprocal multiplication.
module fcd_tap_mod import fcd_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] sum,
  output logic             done,
  output logic [AW-1:0]    rem
);

  // Scaled reciprocal of the depth. The quotient it gives is exact or one short,
  // because the sum stays far below 2^RCP_SH.
  localparam int RCP_SH = SUM_W + 17;
  localparam int RCP_W  = 31;
  localparam int PRD_W  = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP     = RCP_W'((64'd1 << RCP_SH) / DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_V = SUM_W'(DEPTH);

  logic [PRD_W-1:0] prod_r;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] part_r;
  logic             prod_vld_r;
  logic             part_vld_r;
  logic [SUM_W-1:0] quo;
  logic [SUM_W-1:0] quo_x_depth;

  // Estimated quotient and its multiple of the depth.
  always_comb begin
    quo         = SUM_W'(prod_r[PRD_W-1:RCP_SH]);
    quo_x_depth = SUM_W'(quo * DEPTH_V);
  end

  // One compare and subtract finishes the remainder.
  assign rem  = AW'((part_r >= DEPTH_V) ? part_r - DEPTH_V : part_r);
  assign done = part_vld_r;

  // Control: the start pulse passes through prod_vld_r and then part_vld_r, which gives done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      part_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= start;
      part_vld_r <= prod_vld_r;
    end
  end

  // Data: reciprocal product, then the partial remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      sum_r  <= sum;
      prod_r <= PRD_W'(sum) * PRD_W'(RCP);
    end
    if (prod_vld_r) begin
      part_r <= sum_r - quo_x_depth;
    end
  end

endmodule

### verif/testbench.sv
// Self-checking testbench for the flanger / chorus modulated delay block.
module testbench;
  import fcd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 4096;
  localparam int CYCLE_LIMIT = 1000000;
  // Tail wait that covers the tap reduction after the last result.
  localparam int TAIL_CYCLES = 40;
  localparam int IDLE_PCT    = 31;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 200;
  localparam longint Q31     = 64'sd2147483648;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [CFG_AW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SPARE_HI = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic [15:0]       in_tdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [15:0]       out_tdata;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  flanger_chorus_delay #(.STORE_DEPTH(STORE_DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block's registers and delay line.
  logic signed [WORD_W-1:0] echo_mem [STORE_DEPTH];
  logic [11:0]              wr_ptr, near_ptr, far_ptr;
  logic [POS_W-1:0]         sweep_pos;
  int                       sweep_step;
  logic signed [GAIN_W-1:0] dry_q, wet_q, fb_q;
  logic signed [RATE_W-1:0] rate_q;
  logic [DLY_W-1:0]         depth_q, base_q;

  logic [15:0] sample_backlog [$];
  logic [15:0] mix_expected [$];
  int          samples_sent = 0;
  int          samples_taken = 0;
  int          mixes_seen = 0;
  int          mismatches = 0;
  int          reg_writes = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;

  // Sweep bounds after clamping base and depth.
  function automatic void sweep_limits(output int lo, output int hi);
    int b, dp;
    b = int'(base_q);
    dp = int'(depth_q);
    if (b > STORE_DEPTH - 2) b = STORE_DEPTH - 2;
    hi = STORE_DEPTH - 2 - b;
    if (dp > hi) dp = hi;
    lo = hi - dp;
  endfunction

  // Put the sweep at its midpoint and reload the step from the rate register.
  function automatic void recenter_sweep();
    int lo, hi;
    sweep_limits(lo, hi);
    sweep_pos = {16'((lo + hi) / 2), 16'd0};
    sweep_step = int'(rate_q);
  endfunction

  function automatic void clear_model();
    foreach (echo_mem[i]) echo_mem[i] = '0;
    wr_ptr = '0;
    near_ptr = '0;
    far_ptr = '0;
    dry_q = DRY_RST;
    wet_q = WET_RST;
    fb_q = FB_RST;
    rate_q = RATE_RST;
    depth_q = DEPTH_RST;
    base_q = BASE_RST;
    recenter_sweep();
  endfunction

  function automatic void apply_config(input logic [CFG_AW-1:0] idx,
                                       input logic [CFG_DW-1:0] data);
    case (idx)
      REG_DRY: dry_q = data[GAIN_W-1:0];
      REG_WET: wet_q = data[GAIN_W-1:0];
      REG_FB:  fb_q = data[GAIN_W-1:0];
      REG_RATE: begin
        rate_q = data[RATE_W-1:0];
        recenter_sweep();
      end
      REG_DEPTH: begin
        depth_q = data[DLY_W-1:0];
        recenter_sweep();
      end
      REG_BASE: begin
        base_q = data[DLY_W-1:0];
        recenter_sweep();
      end
      default: ;
    endcase
  endfunction

  // Mixed output for one input sample; advances the delay line and the sweep.
  function automatic logic [15:0] mix_sample(input logic [15:0] raw);
    longint xs, nr, fr, frac, d, w, y;
    int     lo, hi, ip;
    xs = longint'($signed(raw));
    frac = longint'(sweep_pos[15:0]);
    nr = longint'(echo_mem[near_ptr]);
    fr = longint'(echo_mem[far_ptr]);
    d = nr * frac + fr * (65536 - frac);

    // Store write: input plus feedback, saturated to the store word.
    w = (xs * Q31 + d * longint'(fb_q)) / Q31;
    if (w > 131071) w = 131071;
    if (w < -131072) w = -131072;
    echo_mem[wr_ptr] = WORD_W'(w);

    // Output mix, saturated to a sample.
    y = (d * longint'(wet_q) + xs * longint'(dry_q) * 65536) / Q31;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;

    wr_ptr = wr_ptr + 12'd1;
    sweep_pos = sweep_pos + POS_W'(sweep_step);
    ip = int'(sweep_pos[31:16]);
    near_ptr = wr_ptr + sweep_pos[27:16];
    far_ptr = near_ptr - 12'd1;
    sweep_limits(lo, hi);
    if (ip > hi || ip < lo) begin
      sweep_step = (sweep_step == -65536) ? 65535 : -sweep_step;
    end
    return 16'(y);
  endfunction

  // Sender: presents queued samples, predicts each one as its request is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        mix_expected.push_back(mix_sample(in_tdata));
        samples_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (sample_backlog.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_tdata <= sample_backlog.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure and comparison against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        mixes_seen++;
        if (mix_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output sample %h", out_tdata);
        end else begin
          logic [15:0] want;
          want = mix_expected.pop_front();
          if (out_tdata !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("output %0d: expected %h got %h", mixes_seen, want, out_tdata);
            end
          end
        end
      end
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout with %0d predictions still waiting", mix_expected.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    apply_config(idx, data);
    reg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold off until every request has its result and the tap update has finished.
  task automatic drain();
    while (samples_taken != samples_sent || mix_expected.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic queue_sample(input logic [15:0] s);
    sample_backlog.push_back(s);
    samples_sent++;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Gain with junk in the unused top bit of the write data.
  function automatic logic [CFG_DW-1:0] pick_gain();
    logic [15:0] g;
    case ($urandom_range(5))
      0: g = 16'h7FFF;
      1: g = 16'h8000;
      2: g = 16'h0000;
      default: g = 16'($urandom);
    endcase
    return {1'($urandom), g};
  endfunction

  function automatic logic [CFG_DW-1:0] pick_rate();
    case ($urandom_range(7))
      0: return STEP_MOST_NEG;
      1: return STEP_MOST_POS;
      2: return 17'h10001;
      3: return '0;
      4, 5: return 17'($urandom_range(3000) - 1500);
      default: return 17'($urandom);
    endcase
  endfunction

  // Delay or depth in samples, junk in the unused upper bits.
  function automatic logic [CFG_DW-1:0] pick_span();
    logic [11:0] v;
    case ($urandom_range(7))
      0: v = 12'd0;
      1: v = 12'd4094;
      2: v = 12'd4095;
      default: v = 12'($urandom_range(200));
    endcase
    return {5'($urandom), v};
  endfunction

  // Stimulus and sequencing of register settings.
  initial begin
    int phases;
    clear_model();
    phases = 3;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: sample extremes into an empty delay line.
    @(negedge clk);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    queue_sample(16'h0000);
    queue_sample(16'hFFFF);
    queue_sample(16'h0001);
    queue_sample(16'h5555);
    queue_sample(16'hAAAA);
    queue_sample(16'h7FFF);
    drain();

    // Base delay past the end, depth clamped to nothing, most negative step,
    // full feedback; the sweep wraps below zero at once.
    write_reg(REG_BASE, 17'd4095);
    write_reg(REG_DEPTH, 17'd4095);
    write_reg(REG_RATE, STEP_MOST_NEG);
    write_reg(REG_FB, 17'h07FFF);
    write_reg(REG_WET, 17'h08000);
    write_reg(REG_DRY, 17'h08000);
    write_reg(REG_SPARE_LO, 17'h1FFFF);
    write_reg(REG_SPARE_HI, 17'h00000);
    @(negedge clk);
    repeat (4) queue_sample(16'h7FFF);
    repeat (4) queue_sample(16'h8000);
    drain();

    // Depth larger than the room left above the base; fastest positive step.
    write_reg(REG_BASE, 17'd100);
    write_reg(REG_DEPTH, 17'd4095);
    write_reg(REG_RATE, STEP_MOST_POS);
    write_reg(REG_FB, 17'h08000);
    write_reg(REG_WET, 17'h07FFF);
    write_reg(REG_DRY, 17'h07FFF);
    @(negedge clk);
    queue_sample(16'h8000);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    queue_sample(16'h7FFF);
    queue_sample(16'h0000);
    queue_sample(16'h8001);
    queue_sample(16'h7FFE);
    queue_sample(16'h0000);
    drain();

    // Random settings, each followed by a burst of random samples.
    for (int p = 0; p < RAND_PHASES; p++) begin
      calm = (p == 3);
      if ($urandom_range(1)) write_reg(REG_DRY, pick_gain());
      if ($urandom_range(1)) write_reg(REG_WET, pick_gain());
      if ($urandom_range(1)) write_reg(REG_FB, pick_gain());
      if ($urandom_range(1)) write_reg(REG_RATE, pick_rate());
      if ($urandom_range(1)) write_reg(REG_DEPTH, pick_span());
      if ($urandom_range(1)) write_reg(REG_BASE, pick_span());
      if ($urandom_range(3) == 0) write_reg(REG_SPARE_HI, 17'($urandom));
      @(negedge clk);
      repeat (PHASE_ITEMS) queue_sample(pick_sample());
      drain();
      phases++;
    end
    calm = 1'b0;

    $display("Ran %0d samples through %0d register settings (%0d writes), %0d outputs checked",
             samples_sent, phases, reg_writes, mixes_seen);
    $display("Covered delay and depth clamping, sweep reversal and wrap, feedback saturation");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
src/fcd_pkg.sv
src/fcd_store.sv
src/fcd_mul.sv
src/fcd_tap_mod.sv
src/flanger_chorus_delay.sv
verif/testbench.sv
